// ===== src/assert_macros.svh =====
// assertion macros shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock, quiet while reset is asserted
`define LRGM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen on a rising clock outside reset
`define LRGM_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/lrgm_pkg.sv =====
// shared constants, command and status types of the resampler
package lrgm_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int GAIN_BITS   = 12;
  localparam int PHASE_W     = 17;
  localparam int SAMPLE_W    = 16;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int RATE_W      = 16;
  localparam int GAIN_W      = 15;
  localparam int PAN_W       = 14;
  localparam int FACT_W      = GAIN_BITS + 1;
  localparam int ACC_W       = 19;
  localparam int MUL_A_W     = ACC_W;
  localparam int MUL_B_W     = 17;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int MIN_RATE    = 64;
  localparam int CFG_W       = 16;
  localparam int IDX_W       = 2;
  localparam int IN_DATA_W   = 2 * SAMPLE_W;
  localparam int OUT_DATA_W  = 2 * SAMPLE_W;

  localparam logic [PHASE_W-1:0] PHASE_UNIT = PHASE_W'(1 << FRAC_BITS);
  localparam logic [RATE_W-1:0]  RATE_MIN   = RATE_W'(MIN_RATE);
  localparam logic [RATE_W-1:0]  RATE_RST   = RATE_W'(4096);
  localparam logic [GAIN_W-1:0]  GAIN_RST   = GAIN_W'(4096);

  typedef enum logic [IDX_W-1:0] {
    REG_STEP_RATE   = 2'd0,
    REG_VOICE_GAIN  = 2'd1,
    REG_PAN         = 2'd2,
    REG_MASTER_GAIN = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_GAIN_L = 4'd2,
    OP_GAIN_R = 4'd3,
    OP_LERP_L = 4'd4,
    OP_LERP_R = 4'd5,
    OP_VG_L   = 4'd6,
    OP_VG_R   = 4'd7,
    OP_MG_L   = 4'd8,
    OP_MG_R   = 4'd9,
    OP_EMIT   = 4'd10,
    OP_FIN    = 4'd11
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic phase_ge_unit;  // no output due at current phase
    logic last_out;       // word being emitted ends the run
    logic out_free;       // output register can take a word
  } dp_sts_t;

endpackage

// ===== src/lrgm_ctrl.sv =====
// sequencer that steps the shared multiplier through one frame
module lrgm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrgm_pkg::dp_sts_t sts_i,
  output lrgm_pkg::dp_cmd_t cmd_o
);
  import lrgm_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_GAIN_L = 11'b000_0000_0010,
    ST_GAIN_R = 11'b000_0000_0100,
    ST_LERP_L = 11'b000_0000_1000,
    ST_LERP_R = 11'b000_0001_0000,
    ST_VG_L   = 11'b000_0010_0000,
    ST_VG_R   = 11'b000_0100_0000,
    ST_MG_L   = 11'b000_1000_0000,
    ST_MG_R   = 11'b001_0000_0000,
    ST_EMIT   = 11'b010_0000_0000,
    ST_FIN    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_GAIN_L;
        end
      end
      ST_GAIN_L: begin
        cmd_o.op = OP_GAIN_L;
        state_d  = ST_GAIN_R;
      end
      ST_GAIN_R: begin
        cmd_o.op = OP_GAIN_R;
        state_d  = sts_i.phase_ge_unit ? ST_FIN : ST_LERP_L;
      end
      ST_LERP_L: begin
        cmd_o.op = OP_LERP_L;
        state_d  = ST_LERP_R;
      end
      ST_LERP_R: begin
        cmd_o.op = OP_LERP_R;
        state_d  = ST_VG_L;
      end
      ST_VG_L: begin
        cmd_o.op = OP_VG_L;
        state_d  = ST_VG_R;
      end
      ST_VG_R: begin
        cmd_o.op = OP_VG_R;
        state_d  = ST_MG_L;
      end
      ST_MG_L: begin
        cmd_o.op = OP_MG_L;
        state_d  = ST_MG_R;
      end
      ST_MG_R: begin
        cmd_o.op = OP_MG_R;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = sts_i.last_out ? ST_FIN : ST_LERP_L;
        end
      end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/lrgm_dp.sv =====
// datapath: config, phase, frame history, shared multiplier, output register
module lrgm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lrgm_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [lrgm_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic signed [lrgm_pkg::SAMPLE_W-1:0] sample_left_i,
  input  logic signed [lrgm_pkg::SAMPLE_W-1:0] sample_right_i,
  input  logic                                restart_i,
  input  lrgm_pkg::dp_cmd_t                   cmd_i,
  output lrgm_pkg::dp_sts_t                   sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [lrgm_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [lrgm_pkg::SAMPLE_W-1:0] out_right_o,
  output logic                                out_last_o
);
  import lrgm_pkg::*;

  localparam logic signed [PAN_W-1:0]  PAN_ONE = PAN_W'(1 << GAIN_BITS);
  localparam logic signed [PAN_W-1:0]  PAN_NEG = -PAN_ONE;
  localparam logic signed [PROD_W-1:0] SAT_HI  = PROD_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO  = -(SAT_HI + PROD_W'(1));

  // configuration
  logic [RATE_W-1:0]       step_rate_q;
  logic [GAIN_W-1:0]       voice_gain_q;
  logic signed [PAN_W-1:0] pan_q;
  logic [GAIN_W-1:0]       master_gain_q;

  // running state
  logic [PHASE_W-1:0]         phase_q;
  logic [CNT_W-1:0]           cnt_q;
  logic signed [SAMPLE_W-1:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  logic [GAIN_W-1:0]          lg_q, rg_q;
  logic signed [ACC_W-1:0]    tmp_l_q, tmp_r_q;
  logic signed [SAMPLE_W-1:0] res_l_q, res_r_q;
  logic                       out_valid_q, out_last_q;
  logic signed [SAMPLE_W-1:0] out_l_q, out_r_q;

  logic [RATE_W-1:0]       rate_eff;
  logic                    unit_rate;
  logic signed [PAN_W-1:0] pan_c, fl_s, fr_s;
  logic [FACT_W-1:0]       fact_l, fact_r;
  logic [PHASE_W-1:0]      phase_next;
  logic signed [DIFF_W-1:0] diff_l, diff_r;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod, prod_g, prod_f;
  logic signed [SAMPLE_W-1:0] prev_sel;
  logic signed [ACC_W-1:0]    lerp_val;
  logic signed [SAMPLE_W-1:0] sat_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_rate_q   <= RATE_RST;
      voice_gain_q  <= GAIN_RST;
      pan_q         <= '0;
      master_gain_q <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP_RATE:   step_rate_q   <= cfg_data_i[RATE_W-1:0];
        REG_VOICE_GAIN:  voice_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_PAN:         pan_q         <= cfg_data_i[PAN_W-1:0];
        REG_MASTER_GAIN: master_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign rate_eff   = (step_rate_q < RATE_MIN) ? RATE_MIN : step_rate_q;
  assign unit_rate  = (PHASE_W'(rate_eff) == PHASE_UNIT);
  assign phase_next = phase_q + PHASE_W'(rate_eff);

  // pan law, clamped to plus or minus one unit
  always_comb begin
    if (pan_q > PAN_ONE) begin
      pan_c = PAN_ONE;
    end else if (pan_q < PAN_NEG) begin
      pan_c = PAN_NEG;
    end else begin
      pan_c = pan_q;
    end
    fl_s   = PAN_ONE - pan_c;
    fr_s   = PAN_ONE + pan_c;
    fact_l = (pan_c <= 0) ? FACT_W'(1 << GAIN_BITS) : fl_s[FACT_W-1:0];
    fact_r = (pan_c >= 0) ? FACT_W'(1 << GAIN_BITS) : fr_s[FACT_W-1:0];
  end

  assign diff_l = {cur_l_q[SAMPLE_W-1], cur_l_q} - {prev_l_q[SAMPLE_W-1], prev_l_q};
  assign diff_r = {cur_r_q[SAMPLE_W-1], cur_r_q} - {prev_r_q[SAMPLE_W-1], prev_r_q};

  // operand select for the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    prev_sel = prev_l_q;
    case (cmd_i.op)
      OP_GAIN_L: begin
        mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, voice_gain_q};
        mul_b = {{(MUL_B_W-FACT_W){1'b0}}, fact_l};
      end
      OP_GAIN_R: begin
        mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, voice_gain_q};
        mul_b = {{(MUL_B_W-FACT_W){1'b0}}, fact_r};
      end
      OP_LERP_L: begin
        mul_a = {{(MUL_A_W-DIFF_W){diff_l[DIFF_W-1]}}, diff_l};
        mul_b = {{(MUL_B_W-FRAC_BITS){1'b0}}, phase_q[FRAC_BITS-1:0]};
      end
      OP_LERP_R: begin
        mul_a    = {{(MUL_A_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
        mul_b    = {{(MUL_B_W-FRAC_BITS){1'b0}}, phase_q[FRAC_BITS-1:0]};
        prev_sel = prev_r_q;
      end
      OP_VG_L: begin
        mul_a = tmp_l_q;
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, lg_q};
      end
      OP_VG_R: begin
        mul_a = tmp_r_q;
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, rg_q};
      end
      OP_MG_L: begin
        mul_a = tmp_l_q;
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, master_gain_q};
      end
      OP_MG_R: begin
        mul_a = tmp_r_q;
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, master_gain_q};
      end
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_g = prod >>> GAIN_BITS;
  assign prod_f = prod >>> FRAC_BITS;

  always_comb begin
    if (unit_rate) begin
      lerp_val = {{(ACC_W-SAMPLE_W){prev_sel[SAMPLE_W-1]}}, prev_sel};
    end else begin
      lerp_val = {{(ACC_W-SAMPLE_W){prev_sel[SAMPLE_W-1]}}, prev_sel} + prod_f[ACC_W-1:0];
    end
    if (prod_g > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_W-1:0];
    end else if (prod_g < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat_val = prod_g[SAMPLE_W-1:0];
    end
  end

  assign sts_o.phase_ge_unit = (phase_q >= PHASE_UNIT);
  assign sts_o.last_out      = (phase_next >= PHASE_UNIT) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

  // phase and frame history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      cnt_q    <= '0;
      prev_l_q <= '0;
      prev_r_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          cnt_q <= '0;
          if (restart_i) begin
            phase_q  <= '0;
            prev_l_q <= '0;
            prev_r_q <= '0;
          end
        end
        OP_EMIT: begin
          phase_q <= phase_next;
          cnt_q   <= cnt_q + CNT_W'(1);
        end
        OP_FIN: begin
          phase_q  <= (phase_q >= PHASE_UNIT) ? phase_q - PHASE_UNIT : '0;
          prev_l_q <= cur_l_q;
          prev_r_q <= cur_r_q;
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cur_l_q <= sample_left_i;
        cur_r_q <= sample_right_i;
      end
      OP_GAIN_L: lg_q    <= prod_g[GAIN_W-1:0];
      OP_GAIN_R: rg_q    <= prod_g[GAIN_W-1:0];
      OP_LERP_L: tmp_l_q <= lerp_val;
      OP_LERP_R: tmp_r_q <= lerp_val;
      OP_VG_L:   tmp_l_q <= prod_g[ACC_W-1:0];
      OP_VG_R:   tmp_r_q <= prod_g[ACC_W-1:0];
      OP_MG_L:   res_l_q <= sat_val;
      OP_MG_R:   res_r_q <= sat_val;
      OP_EMIT: begin
        out_l_q    <= res_l_q;
        out_r_q    <= res_r_q;
        out_last_q <= sts_o.last_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== src/lerp_resample_gain_mix_core.sv =====
// top level of the linear-interpolation stereo resampler with pan and gains
// sequence per source frame: accept, two gain products, then for each output word
//   two interpolation, two voice-gain and two master-gain products and an emit step
//   that waits while the output register is full, then a wrap-up step
// the single shared multiplier sets the pace: six products per output word
// reset: async active low; config returns to defaults, phase and history clear
module lerp_resample_gain_mix_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [lrgm_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [lrgm_pkg::CFG_W-1:0]           cfg_data_i,
  // source frames
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lrgm_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // sample_left, sample_right
  input  logic                                 s_axis_tuser,  // restart
  // mixed output frames
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lrgm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // out_left, out_right
  output logic                                 m_axis_tlast   // last_of_run
);
  import lrgm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [SAMPLE_W-1:0] out_left, out_right;

  // sequencer: one frame at a time, ready only while idle
  lrgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath with its own output register, so the next frame can be
  // taken while the last word of a run still waits downstream
  lrgm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_left_i  (s_axis_tdata[SAMPLE_W-1:0]),
    .sample_right_i (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .restart_i      (s_axis_tuser),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_left_o     (out_left),
    .out_right_o    (out_right),
    .out_last_o     (m_axis_tlast)
  );

  // left in the low half, right in the high half
  assign m_axis_tdata = {out_right, out_left};

endmodule

// ===== src/lrgm_checker.sv =====
// port-level checker for the resampler, bound to the top level
`include "assert_macros.svh"

module lrgm_port_props (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lrgm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  // a stalled output word holds
  `LRGM_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

  // one frame at a time: busy right after a frame is taken
  `LRGM_ASSERT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "frame taken while still busy")

  // a new output word never follows an idle cycle directly
  `LRGM_ASSERT(a_no_word_from_idle, clk_i, rst_ni, s_axis_tready |=> !$rose(m_axis_tvalid), "output word appeared straight from idle")

  // while a run is unfinished no new frame is taken
  `LRGM_NEVER(a_run_open_idle, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast && s_axis_tready, "idle while a run is still open")

endmodule

bind lerp_resample_gain_mix_core lrgm_port_props u_lrgm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
